// ===== rtl/jacobi_four_point_stencil_core_assert.svh =====
// Assertion macros for the Jacobi stencil core.
// No dependencies; included by the top level of the core.
`ifndef JACOBI_FOUR_POINT_STENCIL_CORE_ASSERT_SVH
`define JACOBI_FOUR_POINT_STENCIL_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define JFPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stencil core assertion failed");
`define JFPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stencil core assertion failed");
`else
`define JFPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define JFPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/jfps_pkg.sv =====
// Shared types and constants of the Jacobi stencil core.
// No dependencies; used by every module of the core.
package jfps_pkg;

    localparam int DEF_MAX_COLS    = 1024;
    localparam int DEF_VALUE_WIDTH = 16;

    localparam int CFG_W      = 11;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int HS_VALUE_W = 16;

    localparam logic [CFG_W-1:0]      ROW_MAX          = 11'd2047;
    localparam logic [CFG_W-1:0]      RST_GRID_COLS    = 11'd1000;
    localparam logic [CFG_W-1:0]      RST_GRID_ROWS    = 11'd1000;
    localparam logic [CFG_W-1:0]      RST_HOTSPOT_ROW  = 11'd1;
    localparam logic [CFG_W-1:0]      RST_HOTSPOT_COL  = 11'd1;
    localparam logic [HS_VALUE_W-1:0] RST_HOTSPOT_VAL  = 16'd64000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_COLS      = 3'd0,
        REG_GRID_ROWS      = 3'd1,
        REG_HOTSPOT_ENABLE = 3'd2,
        REG_HOTSPOT_ROW    = 3'd3,
        REG_HOTSPOT_COL    = 3'd4,
        REG_HOTSPOT_VALUE  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0]      cols;
        logic [CFG_W-1:0]      rows;
        logic                  hs_en;
        logic [CFG_W-1:0]      hs_row;
        logic [CFG_W-1:0]      hs_col;
        logic [HS_VALUE_W-1:0] hs_value;
    } cfg_t;

    typedef struct packed {
        logic             emit;
        logic             hot;
        logic             last;
        logic [CFG_W-1:0] row;
        logic [CFG_W-1:0] col;
    } item_info_t;

endpackage

// ===== rtl/jfps_cfg.sv =====
// Configuration registers of the Jacobi stencil core, with grid size clamping.
// Depends on jfps_pkg.
module jfps_cfg
    import jfps_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [CFG_W-1:0]      grid_cols_reg;
    logic [CFG_W-1:0]      grid_rows_reg;
    logic                  hs_en_reg;
    logic [CFG_W-1:0]      hs_row_reg;
    logic [CFG_W-1:0]      hs_col_reg;
    logic [HS_VALUE_W-1:0] hs_value_reg;
    logic [CFG_W-1:0]      cols_c;
    logic [CFG_W-1:0]      rows_c;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= RST_GRID_COLS;
            grid_rows_reg <= RST_GRID_ROWS;
            hs_en_reg     <= 1'b0;
            hs_row_reg    <= RST_HOTSPOT_ROW;
            hs_col_reg    <= RST_HOTSPOT_COL;
            hs_value_reg  <= RST_HOTSPOT_VAL;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_GRID_COLS:      grid_cols_reg <= cfg_data[CFG_W-1:0];
                REG_GRID_ROWS:      grid_rows_reg <= cfg_data[CFG_W-1:0];
                REG_HOTSPOT_ENABLE: hs_en_reg     <= cfg_data[0];
                REG_HOTSPOT_ROW:    hs_row_reg    <= cfg_data[CFG_W-1:0];
                REG_HOTSPOT_COL:    hs_col_reg    <= cfg_data[CFG_W-1:0];
                REG_HOTSPOT_VALUE:  hs_value_reg  <= cfg_data[HS_VALUE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique if (grid_cols_reg == '0)
            cols_c = CFG_W'(1);
        else if (32'(grid_cols_reg) > MAX_COLS)
            cols_c = CFG_W'(MAX_COLS);
        else
            cols_c = grid_cols_reg;

        unique if (grid_rows_reg == '0)
            rows_c = CFG_W'(1);
        else if (32'(grid_rows_reg) > MAX_COLS)
            rows_c = CFG_W'(MAX_COLS);
        else
            rows_c = grid_rows_reg;
    end

    always_comb
    begin
        cfg.cols     = cols_c;
        cfg.rows     = rows_c;
        cfg.hs_en    = hs_en_reg;
        cfg.hs_row   = hs_row_reg;
        cfg.hs_col   = hs_col_reg;
        cfg.hs_value = hs_value_reg;
    end

endmodule

// ===== rtl/jfps_lbuf.sv =====
// Two-line store of the stencil: each entry holds the previous and the
// second previous row at one column. Depends on jfps_pkg.
module jfps_lbuf
    import jfps_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_COLS + 2,
    parameter int VW    = DEF_VALUE_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [VW-1:0]            wr_value,
    output logic [VW-1:0]            east,
    output logic [VW-1:0]            north
);

    localparam int AW = $clog2(DEPTH);

    logic [2*VW-1:0] mem [DEPTH];
    logic [2*VW-1:0] rd_reg;
    logic [AW-1:0]   addr_reg;
    logic [VW-1:0]   val_reg;
    logic            pend_reg;

    // The write of an accepted word lands in the cycle after it is read, so a read of the
    // same entry in that cycle takes the pending data instead.
    always_ff @(posedge clk)
    begin
        if (pend_reg)
            mem[addr_reg] <= {val_reg, rd_reg[2*VW-1:VW]};
        if (rd_en)
        begin
            if (pend_reg && (addr_reg == addr))
                rd_reg <= {val_reg, rd_reg[2*VW-1:VW]};
            else
                rd_reg <= mem[addr];
            addr_reg <= addr;
            val_reg  <= wr_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= rd_en;
    end

    assign east  = rd_reg[2*VW-1:VW];
    assign north = rd_reg[VW-1:0];

endmodule

// ===== rtl/jfps_stencil.sv =====
// Stencil window, four-neighbor mean, hot-spot override and result register.
// Depends on jfps_pkg.
module jfps_stencil
    import jfps_pkg::*;
#(
    parameter int VW = DEF_VALUE_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             take,
    input  item_info_t       info,
    input  logic [VW-1:0]    cur_value,
    input  logic [VW-1:0]    east,
    input  logic [VW-1:0]    north,
    input  logic [VW-1:0]    hs_value,
    output logic             out_valid,
    output logic [VW-1:0]    out_value,
    output logic [CFG_W-1:0] out_row,
    output logic [CFG_W-1:0] out_col,
    output logic             out_last
);

    logic [VW-1:0]    south_reg;
    logic [VW-1:0]    north_reg;
    logic [VW-1:0]    west1_reg;
    logic [VW-1:0]    west2_reg;
    logic [VW+1:0]    sum;
    logic [VW-1:0]    new_value;
    logic             out_valid_reg;
    logic [VW-1:0]    out_value_reg;
    logic [CFG_W-1:0] out_row_reg;
    logic [CFG_W-1:0] out_col_reg;
    logic             out_last_reg;

    always_comb
    begin
        sum = {2'b00, south_reg} + {2'b00, north_reg} + {2'b00, west2_reg} + {2'b00, east};
        new_value = info.hot ? hs_value : sum[VW+1:2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            south_reg <= cur_value;
            north_reg <= north;
            west1_reg <= east;
            west2_reg <= west1_reg;
            if (info.emit)
            begin
                out_value_reg <= new_value;
                out_row_reg   <= info.row;
                out_col_reg   <= info.col;
                out_last_reg  <= info.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= info.emit;
        else if (take)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/jacobi_four_point_stencil_core.sv =====
// Top level of the five-point Jacobi heat stencil core.
// Depends on jfps_pkg, jfps_cfg, jfps_lbuf, jfps_stencil and the assertion header.
//
// The host streams one full plate per pass on the s_axis channel, boundary
// ring included, row by row and left to right, one cell per word. The tuser
// bit marks the top-left boundary cell and restarts the position counters.
// For every interior cell one word leaves on m_axis with the truncated mean
// of its four neighbors (or the hot-spot value), its row and column, and
// tlast on the last interior cell of the pass. The result for cell (r, c) is
// produced by the input word at (r + 1, c + 1); it passes the input stage
// register and the result register before it shows on m_axis_tvalid. The core
// takes one word per cycle while the receiver does not stall, limited by the
// single read and write port of the line store. Configuration words on the
// cfg channel are always taken. Reset clears the counters and loads the
// register defaults; the line store is not cleared and is filled by the
// first two rows of a pass. When the receiver stalls, the result and one
// input word are held, and s_axis_tready drops only while both are waiting.
`include "jacobi_four_point_stencil_core_assert.svh"

module jacobi_four_point_stencil_core
    import jfps_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    // s_axis_tdata: cell_value
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]              s_axis_tdata,
    // s_axis_tuser: start_of_grid
    input  logic                                          s_axis_tuser,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // m_axis_tdata: new_value, out_row, out_col
    output logic [((VALUE_WIDTH+2*CFG_W+7)/8)*8-1:0]      m_axis_tdata,
    output logic                                          m_axis_tlast,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]                          cfg_index,
    input  logic [CFG_DATA_W-1:0]                         cfg_data
);

    localparam int LINE_DEPTH = MAX_COLS + 2;
    localparam int K_W        = $clog2(LINE_DEPTH);
    localparam int CMP_W      = ((K_W > CFG_W) ? K_W : CFG_W) + 2;
    localparam int OUT_DATA_W = ((VALUE_WIDTH + 2*CFG_W + 7) / 8) * 8;

    cfg_t                   cfg;
    logic [K_W-1:0]         col_cnt_reg;
    logic [K_W-1:0]         col_cnt_next;
    logic [CFG_W-1:0]       row_cnt_reg;
    logic [CFG_W-1:0]       row_cnt_next;
    logic [K_W-1:0]         k;
    logic [CFG_W-1:0]       row;
    logic [CMP_W-1:0]       k_x;
    logic [CMP_W-1:0]       row_x;
    logic [CMP_W-1:0]       cols_x;
    logic [CMP_W-1:0]       rows_x;
    logic [CMP_W-1:0]       r_x;
    logic [CMP_W-1:0]       c_x;
    logic                   wrap;
    logic                   in_acc;
    logic                   take;
    logic                   s1_adv;
    logic [VALUE_WIDTH-1:0] v_in;
    item_info_t             info_in;
    logic                   s1_valid_reg;
    logic [VALUE_WIDTH-1:0] v_s1_reg;
    item_info_t             info_s1_reg;
    logic [VALUE_WIDTH-1:0] east;
    logic [VALUE_WIDTH-1:0] north;
    logic                   out_valid;
    logic [VALUE_WIDTH-1:0] out_value;
    logic [CFG_W-1:0]       out_row;
    logic [CFG_W-1:0]       out_col;
    logic                   out_last;

    jfps_cfg #(
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign take          = !out_valid || m_axis_tready;
    assign s1_adv        = s1_valid_reg && take;
    assign s_axis_tready = !s1_valid_reg || take;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign v_in          = s_axis_tdata[VALUE_WIDTH-1:0];

    always_comb
    begin
        k      = s_axis_tuser ? '0 : col_cnt_reg;
        row    = s_axis_tuser ? '0 : row_cnt_reg;
        k_x    = CMP_W'(k);
        row_x  = CMP_W'(row);
        cols_x = CMP_W'(cfg.cols);
        rows_x = CMP_W'(cfg.rows);
        r_x    = row_x - CMP_W'(1);
        c_x    = k_x - CMP_W'(1);
        wrap   = (k_x + CMP_W'(1)) >= (cols_x + CMP_W'(2));

        info_in.emit = (row_x >= CMP_W'(2)) && (row_x <= rows_x + CMP_W'(1)) &&
                       (k_x >= CMP_W'(2)) && (k_x <= cols_x + CMP_W'(1));
        info_in.hot  = cfg.hs_en && (r_x == CMP_W'(cfg.hs_row)) &&
                       (c_x == CMP_W'(cfg.hs_col));
        info_in.last = (r_x == rows_x) && (c_x == cols_x);
        info_in.row  = CFG_W'(r_x);
        info_in.col  = CFG_W'(c_x);
    end

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (in_acc)
        begin
            if (wrap)
            begin
                col_cnt_next = '0;
                row_cnt_next = (row == ROW_MAX) ? row : row + CFG_W'(1);
            end
            else
            begin
                col_cnt_next = K_W'(k_x + CMP_W'(1));
                row_cnt_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            v_s1_reg    <= v_in;
            info_s1_reg <= info_in;
        end
    end

    jfps_lbuf #(
        .DEPTH (LINE_DEPTH),
        .VW    (VALUE_WIDTH)
    ) u_lbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (in_acc),
        .addr     (k),
        .wr_value (v_in),
        .east     (east),
        .north    (north)
    );

    jfps_stencil #(
        .VW (VALUE_WIDTH)
    ) u_stencil (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (s1_adv),
        .take      (take),
        .info      (info_s1_reg),
        .cur_value (v_s1_reg),
        .east      (east),
        .north     (north),
        .hs_value  (VALUE_WIDTH'(cfg.hs_value)),
        .out_valid (out_valid),
        .out_value (out_value),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_last  (out_last)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tlast  = out_last;
    assign m_axis_tdata  = OUT_DATA_W'({out_col, out_row, out_value});

    `JFPS_ASSERT_NEXT(a_start_no_emit, clk, rst_n, in_acc && s_axis_tuser, !info_s1_reg.emit)
    `JFPS_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !take, s1_valid_reg && $stable(v_s1_reg))
    `JFPS_ASSERT_IMPL(a_last_pos, clk, rst_n, out_valid && out_last, out_row == cfg.rows && out_col == cfg.cols)

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the five-point Jacobi stencil core.
// Streams plate grids through jacobi_four_point_stencil_core and checks each result
// word against a stencil predictor kept in the bench; depends on jfps_pkg and the core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jfps_pkg::*;

    localparam int IN_W            = ((DEF_VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_W           = ((DEF_VALUE_WIDTH + 2 * CFG_W + 7) / 8) * 8;
    localparam int LINE_DEPTH      = DEF_MAX_COLS + 2;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_ITEMS    = 1100;
    localparam int MAX_REPORTS     = 10;
    localparam int HOLD_CYCLES     = 400;
    localparam int DIRECTED_LEN    = 22;
    localparam int WIDE_PASS_CELLS = 260;
    localparam int TALL_PASS_CELLS = 330;

    typedef struct packed {
        logic [DEF_VALUE_WIDTH-1:0] value;
        logic [CFG_W-1:0]           row;
        logic [CFG_W-1:0]           col;
        logic                       last;
    } cell_result_t;

    typedef enum logic [1:0] {
        BY_MODEL,
        NO_RESULT,
        TYPED
    } check_kind_t;

    typedef struct {
        logic [DEF_VALUE_WIDTH-1:0] value;
        logic                       sof;
        check_kind_t                kind;
        cell_result_t               typed;
    } directed_row_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    logic [CFG_W-1:0]           cfg_cols = RST_GRID_COLS;
    logic [CFG_W-1:0]           cfg_rows = RST_GRID_ROWS;
    logic                       hs_en    = 1'b0;
    logic [CFG_W-1:0]           hs_row   = RST_HOTSPOT_ROW;
    logic [CFG_W-1:0]           hs_col   = RST_HOTSPOT_COL;
    logic [HS_VALUE_W-1:0]      hs_value = RST_HOTSPOT_VAL;
    int unsigned                pos_row  = 0;
    int unsigned                pos_col  = 0;
    logic [DEF_VALUE_WIDTH-1:0] line_prev  [LINE_DEPTH] = '{default: '0};
    logic [DEF_VALUE_WIDTH-1:0] line_prev2 [LINE_DEPTH] = '{default: '0};
    logic [DEF_VALUE_WIDTH-1:0] win_south = '0;
    logic [DEF_VALUE_WIDTH-1:0] win_north = '0;

    cell_result_t pending_results [$];
    int unsigned  idle_pct     = 0;
    int unsigned  stall_pct    = 0;
    int unsigned  hold_left    = 0;
    int unsigned  fail_count   = 0;
    int unsigned  items_sent   = 0;
    int unsigned  results_seen = 0;
    int unsigned  passes_sent  = 0;
    int unsigned  cfg_writes   = 0;

    // The first two 1x1 grids are laid out as 3x3 rasters, boundary ring included; four more words follow the first.
    directed_row_t directed [DIRECTED_LEN] = '{
        '{16'h0000, 1'b1, NO_RESULT, '0},
        '{16'hFFFF, 1'b0, NO_RESULT, '0},
        '{16'h0000, 1'b0, NO_RESULT, '0},
        '{16'hFFFF, 1'b0, NO_RESULT, '0},
        '{16'h1234, 1'b0, NO_RESULT, '0},
        '{16'hFFFF, 1'b0, NO_RESULT, '0},
        '{16'h0000, 1'b0, NO_RESULT, '0},
        '{16'hFFFF, 1'b0, NO_RESULT, '0},
        '{16'h0000, 1'b0, TYPED, '{16'hFFFF, 11'd1, 11'd1, 1'b1}},
        '{16'hFFFF, 1'b0, NO_RESULT, '0},
        '{16'h8000, 1'b0, NO_RESULT, '0},
        '{16'h0001, 1'b0, NO_RESULT, '0},
        '{16'h7FFF, 1'b0, NO_RESULT, '0},
        '{16'hFFFF, 1'b1, BY_MODEL, '0},
        '{16'h0003, 1'b0, BY_MODEL, '0},
        '{16'hFFFF, 1'b0, BY_MODEL, '0},
        '{16'h0002, 1'b0, BY_MODEL, '0},
        '{16'hFFFF, 1'b0, BY_MODEL, '0},
        '{16'h0001, 1'b0, BY_MODEL, '0},
        '{16'hFFFF, 1'b0, BY_MODEL, '0},
        '{16'h0001, 1'b0, BY_MODEL, '0},
        '{16'hFFFF, 1'b0, BY_MODEL, '0}
    };

    jacobi_four_point_stencil_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int unsigned grid_extent(input logic [CFG_W-1:0] size);
        if (size == 0)
            return 1;
        if (size > DEF_MAX_COLS)
            return DEF_MAX_COLS;
        return size;
    endfunction

    function automatic bit stencil_step(input logic [DEF_VALUE_WIDTH-1:0] v, input logic sof,
                                        output cell_result_t res);
        int unsigned cols;
        int unsigned rows;
        int unsigned k;
        logic [DEF_VALUE_WIDTH+1:0] sum;
        bit emit;
        cols = grid_extent(cfg_cols);
        rows = grid_extent(cfg_rows);
        emit = 1'b0;
        res  = '0;
        if (sof)
        begin
            pos_row = 0;
            pos_col = 0;
        end
        k = (pos_col < LINE_DEPTH) ? pos_col : LINE_DEPTH - 1;
        if (pos_row >= 2 && pos_row <= rows + 1 && k >= 2 && k <= cols + 1)
        begin
            sum = 18'(win_south) + 18'(win_north) + 18'(line_prev2[k-2]) + 18'(line_prev[k]);
            res.value = sum[DEF_VALUE_WIDTH+1:2];
            res.row   = CFG_W'(pos_row - 1);
            res.col   = CFG_W'(k - 1);
            res.last  = (pos_row - 1 == rows) && (k - 1 == cols);
            if (hs_en && res.row == hs_row && res.col == hs_col)
                res.value = hs_value;
            emit = 1'b1;
        end
        win_north     = line_prev2[k];
        win_south     = v;
        line_prev2[k] = line_prev[k];
        line_prev[k]  = v;
        if (k + 1 >= cols + 2)
        begin
            pos_col = 0;
            if (pos_row < ROW_MAX)
                pos_row++;
        end
        else
            pos_col = k + 1;
        return emit;
    endfunction

    function automatic void report_error(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function automatic logic [DEF_VALUE_WIDTH-1:0] cell_sample(input int unsigned mode);
        case (mode)
            2: return 16'hFFFF - 16'($urandom_range(3));
            3: return 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_extent();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 6)
            return CFG_W'($urandom_range(1, 4));
        if (pick < 9)
            return CFG_W'($urandom_range(5, 12));
        return CFG_W'($urandom_range(13, 40));
    endfunction

    function automatic logic [CFG_W-1:0] pick_spot(input int unsigned extent);
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 7)
            return CFG_W'($urandom_range(1, extent));
        if (pick == 7)
            return '0;
        if (pick == 8)
            return CFG_W'(ROW_MAX);
        return CFG_W'($urandom_range(extent + 1, 2047));
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_writes++;
        case (idx)
            REG_GRID_COLS:      cfg_cols = data[CFG_W-1:0];
            REG_GRID_ROWS:      cfg_rows = data[CFG_W-1:0];
            REG_HOTSPOT_ENABLE: hs_en    = data[0];
            REG_HOTSPOT_ROW:    hs_row   = data[CFG_W-1:0];
            REG_HOTSPOT_COL:    hs_col   = data[CFG_W-1:0];
            REG_HOTSPOT_VALUE:  hs_value = data[HS_VALUE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_cell(input logic [DEF_VALUE_WIDTH-1:0] v, input logic sof,
                             input check_kind_t kind = BY_MODEL,
                             input cell_result_t typed = '0);
        cell_result_t res;
        bit emit;
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(v);
        s_axis_tuser  <= sof;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        emit = stencil_step(v, sof, res);
        items_sent++;
        if (kind == TYPED)
            pending_results.push_back(typed);
        else if (kind == BY_MODEL && emit)
            pending_results.push_back(res);
    endtask

    task automatic send_pass(input int unsigned cells);
        int unsigned mode;
        mode = $urandom_range(3);
        passes_sent++;
        for (int unsigned i = 0; i < cells; i++)
            send_cell(cell_sample(mode), i == 0);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        cell_result_t got;
        cell_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.value = m_axis_tdata[DEF_VALUE_WIDTH-1:0];
            got.row   = m_axis_tdata[DEF_VALUE_WIDTH +: CFG_W];
            got.col   = m_axis_tdata[DEF_VALUE_WIDTH + CFG_W +: CFG_W];
            got.last  = m_axis_tlast;
            results_seen++;
            if (pending_results.size() == 0)
                report_error($sformatf("unexpected word: value %h row %0d col %0d last %b",
                                       got.value, got.row, got.col, got.last));
            else
            begin
                want = pending_results.pop_front();
                if (got.value !== want.value || got.row !== want.row ||
                    got.col !== want.col || got.last !== want.last)
                    report_error($sformatf({"expected value %h row %0d col %0d last %b, ",
                                            "got value %h row %0d col %0d last %b"},
                                           want.value, want.row, want.col, want.last,
                                           got.value, got.row, got.col, got.last));
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog expired after %0d cycles without a handshake.", WATCHDOG_LIMIT);
        $display("jacobi_four_point_stencil_core regression: fail");
        $finish;
    end

    initial
    begin : main_flow
        int unsigned      phase;
        int unsigned      n_pass;
        int unsigned      kind;
        int unsigned      total;
        int unsigned      mode;
        logic [CFG_W-1:0] ext_c;
        logic [CFG_W-1:0] ext_r;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_GRID_COLS, 16'd1);
        write_reg(REG_GRID_ROWS, 16'd1);
        cfg_valid <= 1'b0;
        foreach (directed[i])
            send_cell(directed[i].value, directed[i].sof, directed[i].kind, directed[i].typed);
        drain_results();

        phase = 0;
        while (items_sent < DIRECTED_LEN + RANDOM_ITEMS || phase < 4)
        begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 68; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            ext_c = pick_extent();
            ext_r = pick_extent();
            write_reg(REG_GRID_COLS, {5'($urandom), ext_c});
            write_reg(REG_GRID_ROWS, {5'($urandom), ext_r});
            if (phase == 0)
                write_reg(REG_HOTSPOT_ENABLE, 16'd1);
            else
            begin
                if ($urandom_range(9) < 7)
                    write_reg(REG_HOTSPOT_ENABLE, {15'($urandom), 1'($urandom)});
                if ($urandom_range(9) < 7)
                    write_reg(REG_HOTSPOT_ROW, {5'($urandom), pick_spot(ext_r)});
                if ($urandom_range(9) < 7)
                    write_reg(REG_HOTSPOT_COL, {5'($urandom), pick_spot(ext_c)});
                if ($urandom_range(9) < 7)
                    write_reg(REG_HOTSPOT_VALUE, 16'($urandom));
            end
            cfg_valid <= 1'b0;
            n_pass = $urandom_range(1, 4);
            if (phase == 2)
            begin
                n_pass    = 4;
                hold_left = HOLD_CYCLES;
            end
            for (int unsigned p = 0; p < n_pass; p++)
            begin
                total = (grid_extent(cfg_rows) + 2) * (grid_extent(cfg_cols) + 2);
                kind  = $urandom_range(9);
                if (p == 0 || kind < 8)
                    send_pass(total);
                else if (kind == 8)
                    send_pass($urandom_range(1, total - 1));
                else
                begin
                    mode = $urandom_range(3);
                    repeat ($urandom_range(1, 8))
                        send_cell(cell_sample(mode), $urandom_range(3) == 0);
                end
                if ($urandom_range(7) == 0)
                    drain_results();
            end
            drain_results();
            phase++;
        end

        idle_pct  = 21;
        stall_pct = 21;
        write_reg(REG_GRID_COLS, 16'hFFFF);
        write_reg(REG_GRID_ROWS, 16'h0000);
        write_reg(REG_HOTSPOT_ENABLE, 16'hFFFF);
        write_reg(REG_HOTSPOT_ROW, 16'd1);
        write_reg(REG_HOTSPOT_COL, 16'd1024);
        write_reg(REG_HOTSPOT_VALUE, 16'h0000);
        cfg_valid <= 1'b0;
        send_pass(WIDE_PASS_CELLS);
        drain_results();

        write_reg(REG_GRID_COLS, 16'h0000);
        write_reg(REG_GRID_ROWS, 16'd1024);
        write_reg(REG_HOTSPOT_ROW, 16'd100);
        write_reg(REG_HOTSPOT_COL, 16'd1);
        write_reg(REG_HOTSPOT_VALUE, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_pass(TALL_PASS_CELLS);
        drain_results();

        fail_count += pending_results.size();
        $display("Run covered %0d cell words in %0d grid passes and %0d register writes,",
                 items_sent, passes_sent, cfg_writes);
        $display("including clamped full-width and full-height sizes; %0d result words checked.",
                 results_seen);
        if (fail_count == 0)
            $display("jacobi_four_point_stencil_core regression: pass");
        else
            $display("jacobi_four_point_stencil_core regression: fail");
        $finish;
    end

endmodule
